FILE: rtl/core/rec_pkg.sv
// Package: shared types, constants and helpers of the exponential convolution unit.
package rec_pkg;

  localparam int unsigned NPTS = 1024;
  localparam int unsigned SW   = 16;
  localparam int unsigned RW   = 32;
  localparam int unsigned IW   = 10;
  localparam int unsigned NW   = 11;
  localparam int unsigned DW   = 15;
  localparam int unsigned CIW  = 3;
  localparam int unsigned CDW  = 16;
  localparam int unsigned FRAC = 14;

  localparam logic [NW-1:0]         RST_POINTS = 11'd1024;
  localparam logic signed [SW-1:0]  RST_P      = 16'sd6028;
  localparam logic signed [SW-1:0]  RST_Q      = 16'sd4328;
  localparam logic signed [SW-1:0]  RST_R      = -16'sd849;
  localparam logic [DW-1:0]         RST_DECAY  = 15'd6028;
  localparam logic [NW-1:0]         MIN_POINTS = 11'd3;

  typedef enum logic [CIW-1:0] {
    CFG_POINTS = 3'd0,
    CFG_P      = 3'd1,
    CFG_Q      = 3'd2,
    CFG_R      = 3'd3,
    CFG_DECAY  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FINIT,
    ST_RC,
    ST_RN,
    ST_RX,
    ST_MUL,
    ST_ACC,
    ST_WB,
    ST_BINIT
  } state_e;

  typedef struct packed {
    logic idle;
    logic init_fwd;
    logic init_bwd;
    logic iss_c;
    logic iss_nb;
    logic iss_x;
    logic mul;
    logic acc;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic last_j;
    logic bwd;
  } sts_t;

  function automatic logic signed [RW-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh07FFFFFFF;
    lo = -36'sh080000000;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[RW-1:0];
  endfunction

endpackage

FILE: rtl/core/rec_if.sv
// Interfaces: input and output transaction channels.
interface rec_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [rec_pkg::SW-1:0]  sample;
  logic                           final_sample;
  logic [rec_pkg::IW-1:0]         read_index;

  modport source (output valid, cmd, sample, final_sample, read_index, input ready);
  modport sink (input valid, cmd, sample, final_sample, read_index, output ready);
endinterface

interface rec_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [rec_pkg::RW-1:0]  result;
  logic [rec_pkg::IW-1:0]         result_index;

  modport source (output valid, result, result_index, input ready);
  modport sink (input valid, result, result_index, output ready);
endinterface

FILE: rtl/core/rec_ctrl.sv
// Controller: sequences the forward and backward sweeps point by point.
module rec_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rec_pkg::sts_t  sts_i,
  output rec_pkg::cmd_t  cmd_o
);

  rec_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rec_pkg::ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (sts_i.start) state_d = rec_pkg::ST_FINIT;
      end
      rec_pkg::ST_FINIT: begin
        cmd_o.init_fwd = 1'b1;
        state_d = rec_pkg::ST_RC;
      end
      rec_pkg::ST_RC: begin
        cmd_o.iss_c = 1'b1;
        state_d = rec_pkg::ST_RN;
      end
      rec_pkg::ST_RN: begin
        cmd_o.iss_nb = 1'b1;
        state_d = rec_pkg::ST_RX;
      end
      rec_pkg::ST_RX: begin
        cmd_o.iss_x = 1'b1;
        state_d = rec_pkg::ST_MUL;
      end
      rec_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = rec_pkg::ST_ACC;
      end
      rec_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = rec_pkg::ST_WB;
      end
      rec_pkg::ST_WB: begin
        cmd_o.wb = 1'b1;
        if (!sts_i.last_j) begin
          state_d = rec_pkg::ST_RC;
        end else if (sts_i.bwd) begin
          state_d = rec_pkg::ST_IDLE;
        end else begin
          state_d = rec_pkg::ST_BINIT;
        end
      end
      rec_pkg::ST_BINIT: begin
        cmd_o.init_bwd = 1'b1;
        state_d = rec_pkg::ST_RC;
      end
      default: begin
        state_d = rec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/rec_dp.sv
// Datapath: configuration, sample/sweep/result memories, weight and sweep arithmetic.
module rec_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rec_in_if.sink                       in_i,
  rec_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [rec_pkg::CIW-1:0]      cfg_idx_i,
  input  logic [rec_pkg::CDW-1:0]      cfg_data_i,
  input  rec_pkg::cmd_t                cmd_i,
  output rec_pkg::sts_t                sts_o
);

  logic [rec_pkg::NW-1:0]         pc_q;
  logic signed [rec_pkg::SW-1:0]  p_q, q_q, r_q;
  logic [rec_pkg::DW-1:0]         dec_q;

  logic [rec_pkg::NW-1:0]         load_pos_q;
  logic [rec_pkg::IW-1:0]         j_q;
  logic                           bwd_q;
  logic signed [rec_pkg::RW-1:0]  carry_q;
  logic                           out_vld_q;
  logic [rec_pkg::IW-1:0]         res_idx_q;

  logic signed [rec_pkg::SW-1:0]  smem [rec_pkg::NPTS];
  logic signed [rec_pkg::RW-1:0]  lmem [rec_pkg::NPTS];
  logic signed [rec_pkg::RW-1:0]  rmem [rec_pkg::NPTS];
  logic signed [rec_pkg::SW-1:0]  s_rd_q;
  logic signed [rec_pkg::RW-1:0]  l_rd_q;
  logic signed [rec_pkg::RW-1:0]  r_rd_q;

  logic signed [rec_pkg::SW-1:0]  c_q, nb_q;
  logic signed [31:0]             p1_q, p2_q;
  logic signed [33:0]             p3_q;
  logic signed [47:0]             pd_q;

  logic                           acc_in, ld_acc, rd_acc, s_we;
  logic [rec_pkg::NW-1:0]         n;
  logic [rec_pkg::IW-1:0]         nm1, nm2;
  logic [rec_pkg::IW-1:0]         s_raddr;
  logic signed [17:0]             d2;
  logic signed [21:0]             jw;
  logic signed [35:0]             carry_sum;
  logic signed [rec_pkg::RW-1:0]  res_val;
  logic                           l_we, r_we;
  logic signed [rec_pkg::RW-1:0]  l_wdata, r_wdata;

  assign in_i.ready = cmd_i.idle && (!out_vld_q || out_o.ready);
  assign acc_in     = in_i.valid && in_i.ready;
  assign ld_acc     = acc_in && (rec_pkg::cmd_e'(in_i.cmd) == rec_pkg::CMD_LOAD);
  assign rd_acc     = acc_in && (rec_pkg::cmd_e'(in_i.cmd) == rec_pkg::CMD_READ);
  assign s_we       = ld_acc && (load_pos_q < rec_pkg::NW'(rec_pkg::NPTS));

  always_comb begin
    if (pc_q < rec_pkg::MIN_POINTS) begin
      n = rec_pkg::MIN_POINTS;
    end else if (pc_q > rec_pkg::NW'(rec_pkg::NPTS)) begin
      n = rec_pkg::NW'(rec_pkg::NPTS);
    end else begin
      n = pc_q;
    end
  end

  assign nm1 = rec_pkg::IW'(n - 11'd1);
  assign nm2 = rec_pkg::IW'(n - 11'd2);

  assign sts_o.start  = ld_acc && in_i.final_sample;
  assign sts_o.bwd    = bwd_q;
  assign sts_o.last_j = bwd_q ? (j_q == '0) : (j_q == nm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= rec_pkg::RST_POINTS;
      p_q   <= rec_pkg::RST_P;
      q_q   <= rec_pkg::RST_Q;
      r_q   <= rec_pkg::RST_R;
      dec_q <= rec_pkg::RST_DECAY;
    end else if (cfg_we_i) begin
      case (rec_pkg::cfg_reg_e'(cfg_idx_i))
        rec_pkg::CFG_POINTS: pc_q  <= cfg_data_i[rec_pkg::NW-1:0];
        rec_pkg::CFG_P:      p_q   <= cfg_data_i;
        rec_pkg::CFG_Q:      q_q   <= cfg_data_i;
        rec_pkg::CFG_R:      r_q   <= cfg_data_i;
        rec_pkg::CFG_DECAY:  dec_q <= cfg_data_i[rec_pkg::DW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      out_vld_q  <= 1'b0;
      j_q        <= '0;
      bwd_q      <= 1'b0;
      carry_q    <= '0;
    end else begin
      if (ld_acc) begin
        if (in_i.final_sample) begin
          load_pos_q <= '0;
        end else if (s_we) begin
          load_pos_q <= load_pos_q + 11'd1;
        end
      end
      if (rd_acc) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (sts_o.start) begin
        j_q <= '0;
      end else if (cmd_i.init_fwd) begin
        j_q     <= rec_pkg::IW'(1);
        bwd_q   <= 1'b0;
        carry_q <= '0;
      end else if (cmd_i.init_bwd) begin
        j_q     <= nm2;
        bwd_q   <= 1'b1;
        carry_q <= '0;
      end else if (cmd_i.acc) begin
        carry_q <= rec_pkg::sat32(carry_sum);
      end else if (cmd_i.wb && !sts_o.last_j) begin
        j_q <= bwd_q ? (j_q - rec_pkg::IW'(1)) : (j_q + rec_pkg::IW'(1));
      end
    end
  end

  always_comb begin
    s_raddr = j_q;
    if (cmd_i.iss_nb) begin
      s_raddr = bwd_q ? (j_q + rec_pkg::IW'(1)) : (j_q - rec_pkg::IW'(1));
    end else if (cmd_i.iss_x) begin
      if (bwd_q) begin
        s_raddr = (j_q == '0) ? nm2 : (j_q - rec_pkg::IW'(1));
      end else begin
        s_raddr = (j_q == nm1) ? rec_pkg::IW'(1) : (j_q + rec_pkg::IW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[load_pos_q[rec_pkg::IW-1:0]] <= in_i.sample;
    end
    s_rd_q <= smem[s_raddr];
  end

  assign l_we    = cmd_i.init_fwd || (cmd_i.wb && !bwd_q);
  assign l_wdata = cmd_i.init_fwd ? '0 : carry_q;
  assign res_val = rec_pkg::sat32(36'(l_rd_q) + 36'(carry_q));
  assign r_we    = cmd_i.init_bwd || (cmd_i.wb && bwd_q);
  assign r_wdata = cmd_i.init_bwd ? carry_q : res_val;

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      lmem[j_q] <= l_wdata;
    end
    l_rd_q <= lmem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rmem[j_q] <= r_wdata;
    end
    if (rd_acc) begin
      r_rd_q    <= rmem[in_i.read_index];
      res_idx_q <= in_i.read_index;
    end
  end

  assign d2 = 18'(nb_q) + 18'(s_rd_q) - 18'(c_q) - 18'(c_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.iss_nb) begin
      c_q <= s_rd_q;
    end
    if (cmd_i.iss_x) begin
      nb_q <= s_rd_q;
    end
    if (cmd_i.mul) begin
      p1_q <= p_q * c_q;
      p2_q <= q_q * nb_q;
      p3_q <= r_q * d2;
      pd_q <= $signed({1'b0, dec_q}) * carry_q;
    end
  end

  assign jw = 22'(p1_q >>> rec_pkg::FRAC) + 22'(p2_q >>> rec_pkg::FRAC)
            + 22'(p3_q >>> rec_pkg::FRAC);
  assign carry_sum = 36'(jw) + 36'(pd_q >>> rec_pkg::FRAC);

  assign out_o.valid        = out_vld_q;
  assign out_o.result       = r_rd_q;
  assign out_o.result_index = res_idx_q;

endmodule

FILE: rtl/core/recursive_exponential_convolution_unit.sv
// Top level: recursive exponential convolution quadrature unit.
// Loads (cmd 0) and reads (cmd 1) are accepted only while the unit is idle; a read
// returns its result in the next cycle through the output register, and a waiting result
// does not block further loads or reads once it is taken. The load carrying final_sample
// starts the compute, during which no input is accepted: a forward sweep over points 1..n-1
// and a backward sweep over points n-2..0, each point stepping through RC, RN, RX (sample
// memory reads), MUL, ACC (shared multiply/accumulate step) and WB; n is point_count
// clamped to 3..1024. Results are defined only for points written by a compute.
module recursive_exponential_convolution_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rec_in_if.sink                   in_i,
  rec_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [rec_pkg::CIW-1:0]  cfg_idx_i,
  input  logic [rec_pkg::CDW-1:0]  cfg_data_i
);

  rec_pkg::cmd_t cmd;
  rec_pkg::sts_t sts;

  rec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rec_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: test/recursive_exponential_convolution_unit_test.sv
// Testbench: checks loads, computes and indexed reads of the convolution unit against a predictor.
module recursive_exponential_convolution_unit_test;

  typedef struct {
    rec_pkg::cmd_e      op;
    logic signed [15:0] smp;
    logic               fin;
    logic [9:0]         idx;
    logic               known;
    logic signed [31:0] want;
  } stim_t;

  typedef struct {
    logic signed [31:0] value;
    logic [9:0]         index;
  } readout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rec_pkg::CIW-1:0] cfg_idx_i = '0;
  logic [rec_pkg::CDW-1:0] cfg_data_i = '0;

  rec_in_if in_ch ();
  rec_out_if out_ch ();

  recursive_exponential_convolution_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  longint unsigned cycle_count = 0;
  int errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  readout_t pending_reads[$];
  logic signed [31:0] typed_values[$];
  logic typed_flags[$];

  logic signed [31:0] samples[rec_pkg::NPTS];
  logic signed [31:0] left_sweep[rec_pkg::NPTS];
  logic signed [31:0] point_results[rec_pkg::NPTS];
  int unsigned        load_pos;
  int unsigned        n_points;
  logic signed [31:0] p_w, q_w, r_w;
  longint             decay;
  int unsigned        max_written;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd40_000_000) begin
      $display("recursive_exponential_convolution_unit_test: done, errors");
      $finish;
    end
  end

  function automatic longint shr14(longint v);
    return v >>> 14;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint local_weight(longint c, longint nb, longint lo, longint hi);
    longint s;
    s = shr14(p_w * c);
    s = clip32(s + shr14(q_w * nb));
    s = clip32(s + shr14(r_w * (hi - 2 * c + lo)));
    return s;
  endfunction

  task automatic run_sweeps();
    longint carry;
    longint hi, lo, w;
    int j;
    carry = 0;
    left_sweep[0] = 0;
    for (j = 1; j < n_points; j++) begin
      hi = (j == n_points - 1) ? longint'(samples[1]) : longint'(samples[j + 1]);
      w = local_weight(longint'(samples[j]), longint'(samples[j - 1]),
                       longint'(samples[j - 1]), hi);
      carry = clip32(w + shr14(decay * carry));
      left_sweep[j] = 32'(carry);
    end
    carry = 0;
    point_results[n_points - 1] = left_sweep[n_points - 1];
    for (j = n_points - 2; j >= 0; j--) begin
      lo = (j == 0) ? longint'(samples[n_points - 2]) : longint'(samples[j - 1]);
      w = local_weight(longint'(samples[j]), longint'(samples[j + 1]), lo,
                       longint'(samples[j + 1]));
      carry = clip32(w + shr14(decay * carry));
      point_results[j] = 32'(clip32(longint'(left_sweep[j]) + carry));
    end
    if (n_points > max_written) max_written = n_points;
  endtask

  task automatic predict(input stim_t s);
    readout_t r;
    if (s.op == rec_pkg::CMD_LOAD) begin
      if (load_pos < rec_pkg::NPTS) begin
        samples[load_pos] = 32'(s.smp);
        load_pos++;
      end
      if (s.fin) begin
        run_sweeps();
        load_pos = 0;
      end
    end else begin
      r.value = point_results[s.idx];
      r.index = s.idx;
      pending_reads.push_back(r);
      typed_values.push_back(s.want);
      typed_flags.push_back(s.known);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  always @(posedge clk_i) begin
    readout_t e;
    logic signed [31:0] tv;
    logic tk;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        report("unexpected transaction", out_ch.result_index, -1);
      end else begin
        e = pending_reads.pop_front();
        tv = typed_values.pop_front();
        tk = typed_flags.pop_front();
        if (out_ch.result !== e.value) report("result", out_ch.result, e.value);
        if (tk && out_ch.result !== tv) report("typed result", out_ch.result, tv);
        if (out_ch.result_index !== e.index) report("result_index", out_ch.result_index, e.index);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic write_cfg(input rec_pkg::cfg_reg_e r, input logic [rec_pkg::CDW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      rec_pkg::CFG_POINTS: begin
        n_points = 32'(v[rec_pkg::NW-1:0]);
        if (n_points < 3) n_points = 3;
        if (n_points > rec_pkg::NPTS) n_points = rec_pkg::NPTS;
      end
      rec_pkg::CFG_P: p_w = 32'($signed(v));
      rec_pkg::CFG_Q: q_w = 32'($signed(v));
      rec_pkg::CFG_R: r_w = 32'($signed(v));
      rec_pkg::CFG_DECAY: decay = 64'(v[rec_pkg::DW-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send(input stim_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= s.op;
    in_ch.sample <= s.smp;
    in_ch.final_sample <= s.fin;
    in_ch.read_index <= s.idx;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict(s);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (12 * rec_pkg::NPTS + 50) @(posedge clk_i);
  endtask

  function automatic stim_t mk(rec_pkg::cmd_e op, logic signed [15:0] smp, logic fin,
                               logic [9:0] idx);
    stim_t s;
    s.op = op; s.smp = smp; s.fin = fin; s.idx = idx; s.known = 1'b0; s.want = '0;
    return s;
  endfunction

  task automatic load_set(input int unsigned cnt, input int mode);
    logic signed [15:0] v;
    int k;
    for (k = 0; k < cnt; k++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = 16'sh7FFF;
        2: v = -16'sh8000;
        default: v = $signed(16'($urandom_range(2000))) - 16'sd1000;
      endcase
      send(mk(rec_pkg::CMD_LOAD, v, k == cnt - 1, '0));
    end
  endtask

  task automatic read_some(input int cnt);
    int k;
    for (k = 0; k < cnt; k++)
      send(mk(rec_pkg::CMD_READ, '0, 1'($urandom_range(1)),
              10'($urandom_range(max_written - 1))));
  endtask

  task automatic random_phase(input int items);
    int done_items;
    int unsigned cnt;
    done_items = 0;
    while (done_items < items) begin
      write_cfg(rec_pkg::CFG_POINTS,
                rec_pkg::CDW'(($urandom_range(9) == 0) ? $urandom_range(200, 2047)
                                                       : $urandom_range(0, 24)));
      write_cfg(rec_pkg::CFG_P, rec_pkg::CDW'($urandom));
      write_cfg(rec_pkg::CFG_Q, rec_pkg::CDW'($urandom));
      write_cfg(rec_pkg::CFG_R, rec_pkg::CDW'($urandom));
      write_cfg(rec_pkg::CFG_DECAY,
                rec_pkg::CDW'(($urandom_range(3) == 0) ? $urandom : $urandom_range(16384)));
      cnt = n_points + (($urandom_range(4) == 0) ? $urandom_range(5) : 0);
      if (cnt > rec_pkg::NPTS + 3) cnt = rec_pkg::NPTS + 3;
      load_set(cnt, $urandom_range(5) == 0 ? 1 + $urandom_range(1) : 0);
      read_some(8 + $urandom_range(16));
      done_items += cnt + 16;
      drain();
    end
  endtask

  stim_t table_rows[$];

  initial begin
    stim_t s;
    int k;
    in_ch.valid = 1'b0;
    in_ch.cmd = rec_pkg::CMD_LOAD;
    in_ch.sample = '0;
    in_ch.final_sample = 1'b0;
    in_ch.read_index = '0;
    load_pos = 0; n_points = rec_pkg::NPTS;
    p_w = 32'(rec_pkg::RST_P); q_w = 32'(rec_pkg::RST_Q); r_w = 32'(rec_pkg::RST_R);
    decay = 64'(rec_pkg::RST_DECAY); max_written = 0;
    foreach (samples[k]) begin
      samples[k] = 0; left_sweep[k] = 0; point_results[k] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero samples give zero everywhere; extremes with small n
    write_cfg(rec_pkg::CFG_POINTS, 16'd3);
    for (k = 0; k < 3; k++) table_rows.push_back(mk(rec_pkg::CMD_LOAD, '0, k == 2, '0));
    for (k = 0; k < 3; k++) begin
      s = mk(rec_pkg::CMD_READ, '0, 1'b0, 10'(k));
      s.known = 1'b1; s.want = '0;
      table_rows.push_back(s);
    end
    table_rows.push_back(mk(rec_pkg::CMD_LOAD, 16'sh7FFF, 1'b0, '0));
    table_rows.push_back(mk(rec_pkg::CMD_LOAD, -16'sh8000, 1'b0, '0));
    table_rows.push_back(mk(rec_pkg::CMD_LOAD, 16'sh7FFF, 1'b0, '0));
    table_rows.push_back(mk(rec_pkg::CMD_LOAD, -16'sh8000, 1'b1, 10'h3FF));
    for (k = 0; k < 3; k++)
      table_rows.push_back(mk(rec_pkg::CMD_READ, 16'shFFFF, 1'b1, 10'(k)));
    foreach (table_rows[k]) send(table_rows[k]);
    drain();

    write_cfg(rec_pkg::CFG_POINTS, 16'd0);
    write_cfg(rec_pkg::CFG_DECAY, 16'd16384);
    load_set(3, 1);
    read_some(3);
    drain();
    write_cfg(rec_pkg::CFG_POINTS, 16'd2047);
    write_cfg(rec_pkg::CFG_P, 16'h7FFF);
    write_cfg(rec_pkg::CFG_Q, 16'h8000);
    write_cfg(rec_pkg::CFG_R, 16'h7FFF);
    write_cfg(rec_pkg::CFG_DECAY, 16'h7FFF);
    load_set(rec_pkg::NPTS + 2, 0);
    read_some(6);
    send(mk(rec_pkg::CMD_READ, '0, 1'b0, 10'h3FF));
    drain();

    src_idle_pct = 17; snk_idle_pct = 62;
    random_phase(80);
    src_idle_pct = 62; snk_idle_pct = 17;
    random_phase(80);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_phase(80);
    drain();

    if (errors == 0 && pending_reads.size() == 0) begin
      $display("recursive_exponential_convolution_unit_test: done, clean");
    end else begin
      $display("recursive_exponential_convolution_unit_test: done, errors");
    end
    $finish;
  end
endmodule
